[hdl/tgpg_pkg.sv]
// Package: shared types and constants for the text glyph pixel generator.
`timescale 1ns / 1ps
package tgpg_pkg;

  localparam int unsigned STORE_DEPTH = 2048;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
  localparam int unsigned GLYPH_W     = 7;
  localparam int unsigned COLOR_W     = 12;
  localparam int unsigned HALF_W      = 16;
  localparam int unsigned PERIOD_W    = 18;
  localparam int unsigned NUM_LANES   = 2;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;

  localparam logic [HALF_W-1:0] RUN_ONE_CODE   = 16'd4096;
  localparam logic [HALF_W-1:0] RUN_THREE_CODE = 16'd12288;
  localparam logic [HALF_W-1:0] RUN_SEVEN_CODE = 16'd28672;

  localparam logic [COLOR_W-1:0]  FG_RESET     = 12'd4095;
  localparam logic [COLOR_W-1:0]  BG_RESET     = 12'd0;
  localparam logic [COLOR_W-1:0]  BORDER_RESET = 12'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 18'd125000;

  localparam logic [2:0] RENDER_LAST = 3'd6;
  localparam logic [2:0] BORDER_LAST = 3'd2;

  typedef enum logic [1:0] {
    CMD_RENDER = 2'd0,
    CMD_BORDER = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_STORE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FG      = 3'd0,
    REG_BG      = 3'd1,
    REG_BORDER  = 3'd2,
    REG_ALT     = 3'd3,
    REG_EIGHTY  = 3'd4,
    REG_PERIOD  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [7:0]          char_first;
    logic [7:0]          char_second;
    logic [2:0]          glyph_row;
    logic [STORE_AW-1:0] store_address;
    logic [GLYPH_W-1:0]  store_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  fg;
    logic [COLOR_W-1:0]  bg;
    logic [COLOR_W-1:0]  border;
    logic                alt;
    logic                eighty;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  // merge stage status seen by the top level
  typedef struct packed {
    logic       busy;
    logic       border;
    logic [2:0] cnt;
  } mrg_stat_t;

endpackage

[hdl/tgpg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tgpg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/tgpg_lane.sv]
// Glyph lane: own copy of the glyph store, row lookup and flash inversion.
`timescale 1ns / 1ps
module tgpg_lane (
  input  logic                           clk,
  input  logic                           we,
  input  logic [tgpg_pkg::STORE_AW-1:0]  waddr,
  input  logic [tgpg_pkg::GLYPH_W-1:0]   wdata,
  input  logic                           re,
  input  logic [7:0]                     code,
  input  logic [2:0]                     row,
  input  logic                           flash,
  input  logic                           alt,
  output logic [tgpg_pkg::GLYPH_W-1:0]   bits
);
  import tgpg_pkg::*;

  logic [7:0]         code_r;
  logic               flash_r;
  logic [GLYPH_W-1:0] rdata;
  logic               invert;

  tgpg_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr ({code, row}),
    .rdata (rdata)
  );

  // code and flash phase travel alongside the read
  always_ff @(posedge clk) begin
    if (re) begin
      code_r  <= code;
      flash_r <= flash;
    end
  end

  assign invert = !alt && !code_r[7] && code_r[6] && flash_r;
  assign bits   = rdata ^ {GLYPH_W{invert}};

endmodule

[hdl/tgpg_merge.sv]
// Merge stage: joins lane rows and serializes pixel-pair words.
`timescale 1ns / 1ps
module tgpg_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tgpg_pkg::cfg_t                cfg,
  input  logic                          s1_valid,
  input  logic                          s1_border,
  input  logic [tgpg_pkg::GLYPH_W-1:0]  bits_first,
  input  logic [tgpg_pkg::GLYPH_W-1:0]  bits_second,
  output logic                          take,
  output tgpg_pkg::mrg_stat_t           stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tgpg_pkg::out_item_t           out_data
);
  import tgpg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 border_r, border_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic [2*GLYPH_W-1:0] bits_r, bits_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 emit;
  logic                 last_word;
  logic [HALF_W-1:0]    run;
  logic [HALF_W-1:0]    fore;
  logic [HALF_W-1:0]    back;
  logic [HALF_W-1:0]    bord;
  logic [HALF_W-1:0]    lo;
  logic [HALF_W-1:0]    hi;

  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign last_word = border_r ? (cnt_r == BORDER_LAST) : (cnt_r == RENDER_LAST);
  assign take      = s1_valid && (!busy_r || (emit && last_word));

  assign run  = cfg.eighty ? '0 : RUN_ONE_CODE;
  assign fore = {{(HALF_W-COLOR_W){1'b0}}, cfg.fg} | run;
  assign back = {{(HALF_W-COLOR_W){1'b0}}, cfg.bg} | run;
  assign bord = {{(HALF_W-COLOR_W){1'b0}}, cfg.border} |
                ((cnt_r == BORDER_LAST) ? RUN_THREE_CODE : RUN_SEVEN_CODE);

  always_comb begin
    if (border_r) begin
      lo = bord;
      hi = bord;
    end else begin
      lo = bits_r[2*GLYPH_W-1] ? back : fore;
      hi = bits_r[2*GLYPH_W-2] ? back : fore;
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    border_nxt = border_r;
    cnt_nxt    = cnt_r;
    bits_nxt   = bits_r;
    if (take) begin
      busy_nxt   = 1'b1;
      border_nxt = s1_border;
      cnt_nxt    = '0;
      // 80-column: aux page leads
      bits_nxt   = cfg.eighty ? {bits_second, bits_first} : {bits_first, bits_second};
    end else if (emit) begin
      busy_nxt = !last_word;
      cnt_nxt  = cnt_r + 3'd1;
      bits_nxt = {bits_r[2*GLYPH_W-3:0], 2'b00};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.pixel_word = {hi, lo};
      out_data_nxt.last       = last_word;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      border_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      border_r    <= border_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r     <= bits_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.busy   = busy_r;
  assign stat.border = border_r;
  assign stat.cnt    = cnt_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

endmodule

[hdl/text_glyph_pixel_generator_core.sv]
// Top level: text-mode glyph pixel generator with two glyph lanes and a merge stage.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------
//   in_      | input     | in_valid/in_ready   | in_data (in_item_t)
//   out_     | output    | out_valid/out_ready | out_data (out_item_t)
//   cfg_     | input     | APB, pready tied 1  | cfg_paddr/pwdata, cfg_prdata
//
// A render transaction yields seven words, one per cycle while out_ready holds
// high; a border transaction yields three. Ticks and store writes yield nothing.
// The merge stage's word counter sets the rate. The first word passes the store
// read at the accepting edge, the merge load and the output register before it
// shows on out_. Reset (rst_n, sync) clears control state and flash timer and
// restores config to its reset values; the glyph store holds garbage until
// written. out_ready low stalls the merge stage, then the lane stage, then in_ready.
`timescale 1ns / 1ps
module text_glyph_pixel_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tgpg_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tgpg_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tgpg_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [tgpg_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [tgpg_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import tgpg_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t     cfg_r, cfg_nxt;
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FG:     cfg_nxt.fg     = cfg_pwdata[COLOR_W-1:0];
        REG_BG:     cfg_nxt.bg     = cfg_pwdata[COLOR_W-1:0];
        REG_BORDER: cfg_nxt.border = cfg_pwdata[COLOR_W-1:0];
        REG_ALT:    cfg_nxt.alt    = cfg_pwdata[0];
        REG_EIGHTY: cfg_nxt.eighty = cfg_pwdata[0];
        REG_PERIOD: cfg_nxt.period = cfg_pwdata[PERIOD_W-1:0];
        default:    cfg_nxt        = cfg_r;  // writes past the map are dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FG:     cfg_prdata = {{(DATA_W-COLOR_W){1'b0}}, cfg_r.fg};
      REG_BG:     cfg_prdata = {{(DATA_W-COLOR_W){1'b0}}, cfg_r.bg};
      REG_BORDER: cfg_prdata = {{(DATA_W-COLOR_W){1'b0}}, cfg_r.border};
      REG_ALT:    cfg_prdata = {{(DATA_W-1){1'b0}}, cfg_r.alt};
      REG_EIGHTY: cfg_prdata = {{(DATA_W-1){1'b0}}, cfg_r.eighty};
      REG_PERIOD: cfg_prdata = {{(DATA_W-PERIOD_W){1'b0}}, cfg_r.period};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg     <= FG_RESET;
      cfg_r.bg     <= BG_RESET;
      cfg_r.border <= BORDER_RESET;
      cfg_r.alt    <= 1'b0;
      cfg_r.eighty <= 1'b0;
      cfg_r.period <= PERIOD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic in_acc;
  cmd_t cmd;
  logic acc_render, acc_border, acc_tick, acc_store;

  assign in_acc     = in_valid && in_ready;
  assign cmd        = cmd_t'(in_data.command);
  assign acc_render = in_acc && (cmd == CMD_RENDER);
  assign acc_border = in_acc && (cmd == CMD_BORDER);
  assign acc_tick   = in_acc && (cmd == CMD_TICK);
  assign acc_store  = in_acc && (cmd == CMD_STORE);

  // ---------------------------------------------------------------------------
  // Flash timer: mask phase toggles when a tick finds the countdown at zero.
  // A render captures the phase as of its own acceptance.
  // ---------------------------------------------------------------------------
  logic                flash_active_r, flash_active_nxt;
  logic [PERIOD_W-1:0] flash_cnt_r, flash_cnt_nxt;

  always_comb begin
    flash_active_nxt = flash_active_r;
    flash_cnt_nxt    = flash_cnt_r;
    if (acc_tick) begin
      if (flash_cnt_r == '0) begin
        flash_active_nxt = !flash_active_r;
        flash_cnt_nxt    = cfg_r.period;
      end else begin
        flash_cnt_nxt = flash_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_active_r <= 1'b0;
      flash_cnt_r    <= '0;
    end else begin
      flash_active_r <= flash_active_nxt;
      flash_cnt_r    <= flash_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Lane stage: one lane per character code, each with its own store copy.
  // Store writes go to both copies; read data holds while the stage stalls.
  // ---------------------------------------------------------------------------
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_border_r, s1_border_nxt;
  logic               s1_take;
  logic [7:0]         lane_code [NUM_LANES];
  logic [GLYPH_W-1:0] lane_bits [NUM_LANES];

  assign lane_code[0] = in_data.char_first;
  assign lane_code[1] = in_data.char_second;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tgpg_lane u_lane (
      .clk   (clk),
      .we    (acc_store),
      .waddr (in_data.store_address),
      .wdata (in_data.store_data),
      .re    (acc_render),
      .code  (lane_code[g]),
      .row   (in_data.glyph_row),
      .flash (flash_active_r),
      .alt   (cfg_r.alt),
      .bits  (lane_bits[g])
    );
  end

  assign in_ready = !s1_valid_r || s1_take;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_border_nxt = s1_border_r;
    if (acc_render || acc_border) begin
      s1_valid_nxt  = 1'b1;
      s1_border_nxt = acc_border;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_border_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_border_r <= s1_border_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Merge stage and output register
  // ---------------------------------------------------------------------------
  mrg_stat_t mst;

  tgpg_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .s1_valid    (s1_valid_r),
    .s1_border   (s1_border_r),
    .bits_first  (lane_bits[0]),
    .bits_second (lane_bits[1]),
    .take        (s1_take),
    .stat        (mst),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    mst.busy |-> ((mst.border && mst.cnt <= BORDER_LAST) ||
                  (!mst.border && mst.cnt <= RENDER_LAST)))
    else $error("merge word counter out of range");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_take) |=> (s1_valid_r && $stable(s1_border_r)))
    else $error("lane stage lost a stalled transaction");

  a_flash_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_tick && flash_cnt_r == '0) |=>
      (flash_active_r != $past(flash_active_r)))
    else $error("flash phase did not toggle at countdown zero");

endmodule
